// ===== hdl/dism_pkg.sv =====
`default_nettype none

package dism_pkg;

  localparam int unsigned SECTOR_SHIFT = 8;
  localparam int unsigned SECTOR_BYTES = 256;

  localparam int unsigned IMAGE_W  = 24;
  localparam int unsigned SECT_W   = IMAGE_W - SECTOR_SHIFT;
  localparam int unsigned QUOT_W   = 13;
  localparam int unsigned IDX_W    = 14;
  localparam int unsigned OFFSET_W = 22;
  localparam int unsigned XFER_W   = 9;
  localparam int unsigned LTRACK_W = 11;
  localparam int unsigned LSECT_W  = 5;
  localparam int unsigned BUF_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Layout thresholds in sectors
  localparam logic [SECT_W-1:0] SECT_SS_SD = SECT_W'(40 * 10 * 1);
  localparam logic [SECT_W-1:0] SECT_SS_DD = SECT_W'(40 * 18 * 1);
  localparam logic [SECT_W-1:0] SECT_DS_SD = SECT_W'(40 * 10 * 2);

  localparam logic [QUOT_W-1:0] TRACK_LOW  = QUOT_W'(33);
  localparam logic [QUOT_W-1:0] TRACK_HIGH = QUOT_W'(95);

  // Reciprocals: s/10 = (s*RECIP_10)>>RECIP_SHIFT, s/18 = ((s>>1)*RECIP_9)>>RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam logic [15:0] RECIP_9     = 16'd58255;

  localparam logic [BYTE_W-1:0] LAST_SECT_SD = BYTE_W'(9);
  localparam logic [BYTE_W-1:0] LAST_SECT_DD = BYTE_W'(17);

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNRECOG   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUF_SMALL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_DISK  = 1'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] track;
    logic [BYTE_W-1:0] side;
    logic [BYTE_W-1:0] sector;
    logic              wr;
    logic [BUF_W-1:0]  buf_size;
  } req_t;

endpackage

`default_nettype wire

// ===== hdl/disk_image_sector_mapper.sv =====
`default_nettype none

// Channel   Handshake              Payload
// in        start / busy           in_track_number, in_side_number, in_sector_number,
//                                  in_is_write, in_buffer_size
// out       out_strobe (1 cycle)   out_status, out_byte_offset, out_transfer_length,
//                                  out_last_track, out_last_side, out_last_sector,
//                                  out_double_density
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle; busy stays low.
// Each result passes the four register stages in order: layout, reciprocal multiply,
// geometry check and offset, result register.
// Synchronous active-low reset clears the config registers and the stage valid bits.
// The receiver cannot stall; results stream out in order.

module disk_image_sector_mapper (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     start,
  output logic                                    busy,
  input  wire  [dism_pkg::BYTE_W-1:0]             in_track_number,
  input  wire  [dism_pkg::BYTE_W-1:0]             in_side_number,
  input  wire  [dism_pkg::BYTE_W-1:0]             in_sector_number,
  input  wire                                     in_is_write,
  input  wire  [dism_pkg::BUF_W-1:0]              in_buffer_size,
  output logic                                    out_strobe,
  output logic [dism_pkg::STAT_W-1:0]             out_status,
  output logic [dism_pkg::OFFSET_W-1:0]           out_byte_offset,
  output logic [dism_pkg::XFER_W-1:0]             out_transfer_length,
  output logic [dism_pkg::LTRACK_W-1:0]           out_last_track,
  output logic                                    out_last_side,
  output logic [dism_pkg::LSECT_W-1:0]            out_last_sector,
  output logic                                    out_double_density,
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire  [dism_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [dism_pkg::IMAGE_W-1:0]            cfg_data
);
  import dism_pkg::*;

  logic [IMAGE_W-1:0] image_bytes_r;
  logic               check_disk_r;

  logic               s1_vld_r, s2_vld_r, s3_vld_r;
  req_t               s1_req_r, s2_req_r, s3_req_r;
  logic [SECT_W-1:0]  s1_sect_r, s2_sect_r;
  logic               s1_frac_ok_r, s2_frac_ok_r;
  logic               s1_mode_r, s2_mode_r;
  logic               s1_dd_r, s2_dd_r, s3_dd_r;
  logic               s1_ds_r, s2_ds_r, s3_ds_r;
  logic [QUOT_W-1:0]  s2_quot_r;
  logic               s3_media_ok_r;
  logic [QUOT_W-1:0]  s3_ltrack_r;
  logic [IDX_W-1:0]   s3_idx_r;

  logic               out_strobe_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [XFER_W-1:0]  out_xfer_r;
  logic [LTRACK_W-1:0] out_ltrack_r;
  logic               out_lside_r;
  logic [LSECT_W-1:0] out_lsect_r;
  logic               out_dd_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_bytes_r <= '0;
      check_disk_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_BYTES: image_bytes_r <= cfg_data;
        REG_CHECK_DISK:  check_disk_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: sector count and layout choice
  logic [SECT_W-1:0] sect_nxt;
  logic              dd_nxt, ds_nxt;
  req_t              req_nxt;

  always_comb begin
    sect_nxt = image_bytes_r[IMAGE_W-1:SECTOR_SHIFT];
    ds_nxt   = sect_nxt > SECT_SS_DD;
    dd_nxt   = ((sect_nxt > SECT_SS_SD) && !ds_nxt) || (sect_nxt > SECT_DS_SD);
    req_nxt.track    = in_track_number;
    req_nxt.side     = in_side_number;
    req_nxt.sector   = in_sector_number;
    req_nxt.wr       = in_is_write;
    req_nxt.buf_size = in_buffer_size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_req_r     <= req_nxt;
    s1_sect_r    <= sect_nxt;
    s1_frac_ok_r <= image_bytes_r[SECTOR_SHIFT-1:0] == '0;
    s1_mode_r    <= check_disk_r;
    s1_dd_r      <= dd_nxt;
    s1_ds_r      <= ds_nxt;
  end

  // Stage 2: sectors divided by sectors per track through a reciprocal
  logic [SECT_W-1:0]   num;
  logic [15:0]         recip;
  logic [2*SECT_W-1:0] prod;
  logic [QUOT_W-1:0]   quot_nxt;

  always_comb begin
    num      = s1_dd_r ? {1'b0, s1_sect_r[SECT_W-1:1]} : s1_sect_r;
    recip    = s1_dd_r ? RECIP_9 : RECIP_10;
    prod     = num * recip;
    quot_nxt = prod[RECIP_SHIFT +: QUOT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_req_r     <= s1_req_r;
    s2_sect_r    <= s1_sect_r;
    s2_frac_ok_r <= s1_frac_ok_r;
    s2_mode_r    <= s1_mode_r;
    s2_dd_r      <= s1_dd_r;
    s2_ds_r      <= s1_ds_r;
    s2_quot_r    <= quot_nxt;
  end

  // Stage 3: media checks, last track and linear sector index
  logic [SECT_W:0]   back;
  logic [QUOT_W-1:0] tracks;
  logic [QUOT_W-1:0] ltrack_nxt;
  logic              range_ok;
  logic              media_ok_nxt;
  logic [BYTE_W:0]   lin;
  logic [IDX_W-1:0]  idx_nxt;

  always_comb begin
    back = s2_dd_r ? ({s2_quot_r, 4'b0} + {3'b0, s2_quot_r, 1'b0})
                   : ({1'b0, s2_quot_r, 3'b0} + {3'b0, s2_quot_r, 1'b0});
    tracks     = s2_ds_r ? {1'b0, s2_quot_r[QUOT_W-1:1]} : s2_quot_r;
    ltrack_nxt = tracks - QUOT_W'(1);
    range_ok   = s2_mode_r || ((ltrack_nxt >= TRACK_LOW) && (ltrack_nxt <= TRACK_HIGH));
    media_ok_nxt = s2_frac_ok_r && (s2_sect_r != '0) && (back == {1'b0, s2_sect_r}) &&
                   (tracks != '0) && range_ok;
    lin = s2_ds_r ? {s2_req_r.track, s2_req_r.side[0]} : {1'b0, s2_req_r.track};
    idx_nxt = (s2_dd_r ? ({1'b0, lin, 4'b0} + {4'b0, lin, 1'b0})
                       : ({2'b0, lin, 3'b0} + {4'b0, lin, 1'b0}))
              + {{(IDX_W-BYTE_W){1'b0}}, s2_req_r.sector};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_req_r      <= s2_req_r;
    s3_dd_r       <= s2_dd_r;
    s3_ds_r       <= s2_ds_r;
    s3_media_ok_r <= media_ok_nxt;
    s3_ltrack_r   <= ltrack_nxt;
    s3_idx_r      <= idx_nxt;
  end

  // Stage 4: access checks and result register
  logic [STAT_W-1:0]   status_nxt;
  logic [OFFSET_W-1:0] offset_nxt;
  logic [XFER_W-1:0]   xfer_nxt;
  logic [LTRACK_W-1:0] ltrack_out_nxt;
  logic                lside_nxt;
  logic [LSECT_W-1:0]  lsect_nxt;
  logic                dd_out_nxt;
  logic                buf_short;
  logic                miss;
  logic [XFER_W-1:0]   len;

  always_comb begin
    buf_short = s3_req_r.buf_size < BUF_W'(SECTOR_BYTES);
    miss = ({{(QUOT_W-BYTE_W){1'b0}}, s3_req_r.track} > s3_ltrack_r) ||
           (s3_ds_r ? (s3_req_r.side > BYTE_W'(1)) : (s3_req_r.side != '0)) ||
           (s3_req_r.sector > (s3_dd_r ? LAST_SECT_DD : LAST_SECT_SD));
    len = (s3_req_r.wr && buf_short) ? s3_req_r.buf_size[XFER_W-1:0]
                                     : XFER_W'(SECTOR_BYTES);
    status_nxt     = ST_OK;
    offset_nxt     = '0;
    xfer_nxt       = '0;
    ltrack_out_nxt = s3_ltrack_r[LTRACK_W-1:0];
    lside_nxt      = s3_ds_r;
    lsect_nxt      = s3_dd_r ? LAST_SECT_DD[LSECT_W-1:0] : LAST_SECT_SD[LSECT_W-1:0];
    dd_out_nxt     = s3_dd_r;
    if (!s3_media_ok_r) begin
      status_nxt     = ST_UNRECOG;
      ltrack_out_nxt = '0;
      lside_nxt      = 1'b0;
      lsect_nxt      = '0;
      dd_out_nxt     = 1'b0;
    end else if (!s3_req_r.wr && buf_short) begin
      status_nxt = ST_BUF_SMALL;
    end else if (miss) begin
      status_nxt = ST_NOT_FOUND;
    end else begin
      offset_nxt = {s3_idx_r, {SECTOR_SHIFT{1'b0}}};
      xfer_nxt   = len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_vld_r;
    end
    out_status_r <= status_nxt;
    out_offset_r <= offset_nxt;
    out_xfer_r   <= xfer_nxt;
    out_ltrack_r <= ltrack_out_nxt;
    out_lside_r  <= lside_nxt;
    out_lsect_r  <= lsect_nxt;
    out_dd_r     <= dd_out_nxt;
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_byte_offset     = out_offset_r;
  assign out_transfer_length = out_xfer_r;
  assign out_last_track      = out_ltrack_r;
  assign out_last_side       = out_lside_r;
  assign out_last_sector     = out_lsect_r;
  assign out_double_density  = out_dd_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 4))
    else $error("result beat without a start four cycles earlier");

  a_unrecog_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_UNRECOG) |->
      (out_byte_offset == '0 && out_last_track == '0 && out_last_sector == '0))
    else $error("unrecognized media beat carries geometry");

  a_fail_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> out_transfer_length == '0)
    else $error("failed access reports a transfer length");

  a_geom_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_UNRECOG) |->
      ((out_double_density && out_last_sector == 5'd17) ||
       (!out_double_density && out_last_sector == 5'd9)))
    else $error("last sector disagrees with density");
`endif

endmodule

`default_nettype wire

// ===== verif/disk_image_sector_mapper_tb.sv =====
module disk_image_sector_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dism_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SPT_SD        = 10;
  localparam int unsigned SPT_DD        = 18;
  localparam int unsigned PHASE_BEATS   = 60;
  localparam int unsigned RAND_BEATS    = 80;
  localparam int unsigned RAND_PHASES   = 10;
  localparam int unsigned CALM_PHASES   = 3;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [OFFSET_W-1:0] offset;
    logic [XFER_W-1:0]   xfer;
    logic [LTRACK_W-1:0] ltrack;
    logic                lside;
    logic [LSECT_W-1:0]  lsect;
    logic                dd;
  } map_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [BYTE_W-1:0]    in_track_number = '0;
  logic [BYTE_W-1:0]    in_side_number = '0;
  logic [BYTE_W-1:0]    in_sector_number = '0;
  logic                 in_is_write = 1'b0;
  logic [BUF_W-1:0]     in_buffer_size = '0;
  logic                 out_strobe;
  logic [STAT_W-1:0]    out_status;
  logic [OFFSET_W-1:0]  out_byte_offset;
  logic [XFER_W-1:0]    out_transfer_length;
  logic [LTRACK_W-1:0]  out_last_track;
  logic                 out_last_side;
  logic [LSECT_W-1:0]   out_last_sector;
  logic                 out_double_density;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IMAGE_W-1:0]   cfg_data = '0;

  logic [IMAGE_W-1:0]   img_bytes_q = '0;
  logic                 chk_disk_q = 1'b0;
  req_t                 req_pending [$];
  map_res_t             map_expected [$];
  req_t                 cur_req = '0;
  int unsigned          gap_left = 0;
  logic                 idle_on = 1'b1;
  int unsigned          mismatches = 0;
  int unsigned          cycle_count = 0;

  disk_image_sector_mapper i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_track_number     (in_track_number),
    .in_side_number      (in_side_number),
    .in_sector_number    (in_sector_number),
    .in_is_write         (in_is_write),
    .in_buffer_size      (in_buffer_size),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_byte_offset     (out_byte_offset),
    .out_transfer_length (out_transfer_length),
    .out_last_track      (out_last_track),
    .out_last_side       (out_last_side),
    .out_last_sector     (out_last_sector),
    .out_double_density  (out_double_density),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic map_res_t map_access(req_t rq, logic [IMAGE_W-1:0] img, logic chk);
    map_res_t    r;
    int unsigned nsect;
    int unsigned spt;
    int unsigned sides;
    int unsigned tracks;
    int unsigned lt;
    logic        media_ok;
    r = '0;
    nsect = img / SECTOR_BYTES;
    if (nsect <= SECT_SS_SD) begin
      spt = SPT_SD;
      sides = 1;
    end else if (nsect <= SECT_SS_DD) begin
      spt = SPT_DD;
      sides = 1;
    end else if (nsect <= SECT_DS_SD) begin
      spt = SPT_SD;
      sides = 2;
    end else begin
      spt = SPT_DD;
      sides = 2;
    end
    tracks = nsect / (spt * sides);
    media_ok = (img % SECTOR_BYTES == 0) && (nsect != 0) && (nsect % spt == 0) && (tracks != 0);
    lt = media_ok ? tracks - 1 : 0;
    if (media_ok && !chk && (lt < TRACK_LOW || lt > TRACK_HIGH))
      media_ok = 1'b0;
    if (!media_ok) begin
      r.status = ST_UNRECOG;
    end else begin
      r.ltrack = LTRACK_W'(lt);
      r.lside = (sides == 2);
      r.lsect = LSECT_W'(spt - 1);
      r.dd = (spt == SPT_DD);
      if (!rq.wr && rq.buf_size < SECTOR_BYTES) begin
        r.status = ST_BUF_SMALL;
      end else if (rq.track > lt || rq.side >= sides || rq.sector >= spt) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.status = ST_OK;
        r.offset = OFFSET_W'(((rq.track * sides + rq.side) * spt + rq.sector) * SECTOR_BYTES);
        r.xfer = (rq.wr && rq.buf_size < SECTOR_BYTES) ? XFER_W'(rq.buf_size)
                                                       : XFER_W'(SECTOR_BYTES);
      end
    end
    return r;
  endfunction

  function automatic req_t rand_req(map_res_t geo);
    req_t        rq;
    int unsigned sel;
    int unsigned track_top;
    rq.track = BYTE_W'($urandom);
    rq.side = BYTE_W'($urandom);
    rq.sector = BYTE_W'($urandom);
    rq.wr = 1'($urandom);
    rq.buf_size = BUF_W'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      track_top = (geo.ltrack >= 255) ? 255 : geo.ltrack + 1;
      rq.track = BYTE_W'($urandom_range(0, track_top));
      rq.side = BYTE_W'($urandom_range(0, geo.lside + 1));
      rq.sector = BYTE_W'($urandom_range(0, geo.lsect + 1));
      sel = $urandom_range(0, 7);
      if (sel == 0)
        rq.buf_size = BUF_W'($urandom_range(0, SECTOR_BYTES - 1));
      else if (sel == 1)
        rq.buf_size = $urandom_range(0, 1) ? BUF_W'(SECTOR_BYTES) : '1;
      else
        rq.buf_size = BUF_W'($urandom_range(SECTOR_BYTES, 65535));
    end
    return rq;
  endfunction

  task automatic push_req(int unsigned trk, int unsigned sd, int unsigned sec, logic wr,
                          int unsigned bsz);
    req_t rq;
    rq.track = BYTE_W'(trk);
    rq.side = BYTE_W'(sd);
    rq.sector = BYTE_W'(sec);
    rq.wr = wr;
    rq.buf_size = BUF_W'(bsz);
    req_pending.push_back(rq);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IMAGE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (req_pending.size() != 0 || start || map_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(logic [IMAGE_W-1:0] img, logic chk);
    write_reg(REG_IMAGE_BYTES, img);
    write_reg(REG_CHECK_DISK, IMAGE_W'(chk));
  endtask

  task automatic run_phase(logic [IMAGE_W-1:0] img, logic chk, int unsigned beats);
    map_res_t geo;
    set_geometry(img, chk);
    geo = map_access('0, img, chk);
    repeat (beats) req_pending.push_back(rand_req(geo));
    drain();
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_BYTES: img_bytes_q <= cfg_data;
        REG_CHECK_DISK:  chk_disk_q <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : drv_blk
    logic fire;
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      fire = start && !busy;
      next_start = start && !fire;
      if (fire)
        map_expected.push_back(map_access(cur_req, img_bytes_q, chk_disk_q));
      if (!next_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_pending.size() != 0) begin
          cur_req = req_pending.pop_front();
          in_track_number <= cur_req.track;
          in_side_number <= cur_req.side;
          in_sector_number <= cur_req.sector;
          in_is_write <= cur_req.wr;
          in_buffer_size <= cur_req.buf_size;
          next_start = 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 19);
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin : mon_blk
    map_res_t want;
    if (rst_n && out_strobe) begin
      if (map_expected.size() == 0) begin
        $display("%0t: result with no beat pending, status %0d offset %0d", $time,
                 out_status, out_byte_offset);
        mismatches++;
      end else begin
        want = map_expected.pop_front();
        check_field("status", want.status, out_status);
        check_field("byte_offset", want.offset, out_byte_offset);
        check_field("transfer_length", want.xfer, out_transfer_length);
        check_field("last_track", want.ltrack, out_last_track);
        check_field("last_side", want.lside, out_last_side);
        check_field("last_sector", want.lsect, out_last_sector);
        check_field("double_density", want.dd, out_double_density);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("disk_image_sector_mapper_tb: FAIL");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned      spt;
    int unsigned      sides;
    int unsigned      tracks;
    logic [IMAGE_W-1:0] img;
    logic             chk;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_req(255, 255, 255, 1'b0, 65535);
    push_req(0, 0, 0, 1'b1, 0);
    drain();

    set_geometry(IMAGE_W'(80 * 18 * 2 * 256), 1'b0);
    push_req(0, 0, 0, 1'b0, 256);
    push_req(79, 1, 17, 1'b0, 65535);
    push_req(80, 0, 0, 1'b0, 256);
    push_req(255, 255, 255, 1'b0, 65535);
    push_req(0, 2, 0, 1'b0, 256);
    push_req(0, 0, 18, 1'b0, 256);
    push_req(0, 0, 0, 1'b0, 255);
    push_req(0, 0, 0, 1'b0, 0);
    push_req(255, 0, 0, 1'b0, 0);
    push_req(0, 0, 0, 1'b1, 0);
    push_req(0, 0, 0, 1'b1, 1);
    push_req(5, 1, 3, 1'b1, 255);
    push_req(5, 1, 3, 1'b1, 256);
    push_req(79, 1, 17, 1'b1, 65535);
    push_req(255, 255, 255, 1'b1, 0);
    drain();

    run_phase(IMAGE_W'(34 * 10 * 256), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(33 * 10 * 256), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(33 * 10 * 256), 1'b1, PHASE_BEATS);
    run_phase(IMAGE_W'(400 * 256), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(720 * 256), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(800 * 256), 1'b0, PHASE_BEATS);
    idle_on = 1'b0;
    run_phase(IMAGE_W'(96 * 36 * 256), 1'b0, PHASE_BEATS);
    idle_on = 1'b1;
    run_phase(IMAGE_W'(97 * 36 * 256), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(97 * 36 * 256), 1'b1, PHASE_BEATS);
    run_phase(IMAGE_W'(65520 * 256), 1'b1, PHASE_BEATS);
    run_phase('1, 1'b1, PHASE_BEATS);
    run_phase(IMAGE_W'(345 * 256), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(34 * 10 * 256 + 1), 1'b0, PHASE_BEATS);
    run_phase(IMAGE_W'(10 * 256), 1'b1, PHASE_BEATS);
    run_phase('0, 1'b1, PHASE_BEATS);

    for (int p = 0; p < RAND_PHASES; p++) begin
      spt = $urandom_range(0, 1) ? SPT_DD : SPT_SD;
      sides = $urandom_range(1, 2);
      tracks = $urandom_range(30, 100);
      img = IMAGE_W'(tracks * spt * sides * SECTOR_BYTES);
      if ($urandom_range(0, 3) == 0)
        img = $urandom_range(0, 1) ? IMAGE_W'($urandom) : img + IMAGE_W'($urandom_range(1, 255));
      chk = ($urandom_range(0, 3) == 0);
      idle_on = (p < RAND_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
      run_phase(img, chk, RAND_BEATS);
    end

    if (mismatches == 0)
      $display("disk_image_sector_mapper_tb: PASS");
    else
      $display("disk_image_sector_mapper_tb: FAIL");
    $finish;
  end

endmodule
